// ===== sv/splstep_pkg.sv =====
// Shared types, constants and saturation helpers for the servo position loop step unit.
package splstep_pkg;

    localparam int ANGLE_W   = 17;
    localparam int POS_W     = 40;
    localparam int TURN_W    = 24;
    localparam int INTEG_W   = 48;
    localparam int ACC_W     = 68;
    localparam int COEF_W    = 17;
    localparam int MOP_W     = 25;
    localparam int PROD_W    = COEF_W + MOP_W;
    localparam int EFF_W     = 12;
    localparam int DRIVE_W   = 19;
    localparam int PC_W      = 16;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    localparam logic [CNT_W-1:0] FILT_STEPS = 4'd10;
    localparam logic [CNT_W-1:0] PID_STEPS  = 4'd6;

    localparam logic signed [18:0] HALF_TURN  = 19'sd46080;
    localparam logic [8:0]         GAIN13_NUM = 9'd333;
    localparam logic [POS_W-1:0]   AT_THRESH  = 40'd13;

    localparam logic [CFG_IDX_W-1:0] REG_PID_GAINS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILT_NUM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILT_DEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EFF_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_BUDGET = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_ADV   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_ERROR,
        ST_FMUL,
        ST_FDONE,
        ST_PMUL,
        ST_FINISH
    } splstep_state_t;

    typedef struct packed {
        logic             accept;
        logic             unwrap;
        logic             error;
        logic             acc_clr;
        logic             mul_issue;
        logic             mul_pid;
        logic [CNT_W-1:0] cnt;
        logic             filt_done;
        logic             finish;
    } splstep_cmd_t;

    typedef struct packed {
        logic en;
        logic out_free;
    } splstep_status_t;

    function automatic logic signed [POS_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'({1'b0, {(POS_W-1){1'b1}}}));
        lo = -hi - 1;
        if (v > hi) begin
            return hi[POS_W-1:0];
        end else if (v < lo) begin
            return lo[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'({1'b0, {(INTEG_W-1){1'b1}}}));
        lo = -hi - 1;
        if (v > hi) begin
            return hi[INTEG_W-1:0];
        end else if (v < lo) begin
            return lo[INTEG_W-1:0];
        end
        return v[INTEG_W-1:0];
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'({1'b0, {63{1'b1}}}));
        lo = -hi - 1;
        if (v > hi) begin
            return hi[63:0];
        end else if (v < lo) begin
            return lo[63:0];
        end
        return v[63:0];
    endfunction

endpackage

// ===== sv/splstep_ctrl.sv =====
// Sequencing state machine for one control tick of the position loop.
module splstep_ctrl
    import splstep_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  splstep_status_t status,
    output splstep_cmd_t    cmd
);

    splstep_state_t   state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid) begin
                    state_next = ST_UNWRAP;
                end
            end
            ST_UNWRAP: begin
                cmd.unwrap = 1'b1;
                state_next = ST_ERROR;
            end
            ST_ERROR: begin
                cmd.error   = 1'b1;
                cmd.acc_clr = 1'b1;
                cnt_next    = '0;
                state_next  = status.en ? ST_FMUL : ST_FINISH;
            end
            ST_FMUL: begin
                if (cnt_reg == FILT_STEPS) begin
                    state_next = ST_FDONE;
                end else begin
                    cmd.mul_issue = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_FDONE: begin
                cmd.filt_done = 1'b1;
                cmd.acc_clr   = 1'b1;
                cnt_next      = '0;
                state_next    = ST_PMUL;
            end
            ST_PMUL: begin
                cmd.mul_pid = 1'b1;
                if (cnt_reg == PID_STEPS) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul_issue = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/splstep_dp.sv =====
// Datapath: configuration registers, loop state, shared multiplier and output register.
module splstep_dp
    import splstep_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DAT_W-1:0]          cfg_wdata,
    input  logic [ANGLE_W-1:0]            in_angle,
    input  logic                          in_enable,
    input  logic                          in_load,
    input  logic signed [POS_W-1:0]       in_target,
    input  splstep_cmd_t                  cmd,
    output splstep_status_t               status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [DRIVE_W-1:0]     out_drive,
    output logic [EFF_W-1:0]              out_effort,
    output logic                          out_at_target,
    output logic signed [POS_W-1:0]       out_position
);

    logic [47:0]         gains_reg, fnum_reg;
    logic [31:0]         fden_reg;
    logic [EFF_W-1:0]    eff_lim_reg, peak_lim_reg;
    logic [14:0]         peak_step_reg, peak_budget_reg;
    logic [ANGLE_W-1:0]  phase_adv_reg;

    logic [ANGLE_W-1:0]        y_reg, last_angle_reg;
    logic                      en_reg;
    logic signed [TURN_W-1:0]  turn_reg;
    logic signed [POS_W-1:0]   held_reg, pos_reg, raw0_reg, e_reg;
    logic signed [POS_W-1:0]   reh0_reg, reh1_reg, feh0_reg, feh1_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [POS_W:0]     diff_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      pend_reg, pend_hi_reg;
    logic signed [PC_W-1:0]    pc_reg;

    logic                        out_valid_reg;
    logic signed [DRIVE_W-1:0]   out_drive_reg;
    logic [EFF_W-1:0]            out_effort_reg;
    logic                        out_at_reg;
    logic signed [POS_W-1:0]     out_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg       <= '0;
            fnum_reg        <= 48'd16384;
            fden_reg        <= '0;
            eff_lim_reg     <= '0;
            peak_lim_reg    <= '0;
            peak_step_reg   <= 15'd1;
            peak_budget_reg <= '0;
            phase_adv_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PID_GAINS:   gains_reg       <= cfg_wdata;
                REG_FILT_NUM:    fnum_reg        <= cfg_wdata;
                REG_FILT_DEN:    fden_reg        <= cfg_wdata[31:0];
                REG_EFF_LIMIT:   eff_lim_reg     <= cfg_wdata[EFF_W-1:0];
                REG_PEAK_LIMIT:  peak_lim_reg    <= cfg_wdata[EFF_W-1:0];
                REG_PEAK_STEP:   peak_step_reg   <= cfg_wdata[14:0];
                REG_PEAK_BUDGET: peak_budget_reg <= cfg_wdata[14:0];
                REG_PHASE_ADV:   phase_adv_reg   <= cfg_wdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // unwrap
    logic signed [18:0]       delta;
    logic signed [TURN_W-1:0] turn_new;
    logic signed [41:0]       turn_ext, pos_sum;

    always_comb begin
        delta = signed'({2'b00, y_reg}) - signed'({2'b00, last_angle_reg});
        if (delta < -HALF_TURN) begin
            turn_new = turn_reg + 1'b1;
        end else if (delta > HALF_TURN) begin
            turn_new = turn_reg - 1'b1;
        end else begin
            turn_new = turn_reg;
        end
        turn_ext = 42'(turn_new);
        pos_sum  = (turn_ext <<< 16) + (turn_ext <<< 14) + (turn_ext <<< 13)
                 + (turn_ext <<< 11) + signed'({25'd0, y_reg});
    end

    // shared multiplier operand select
    logic [2:0]                pair;
    logic signed [COEF_W-1:0]  coef;
    logic signed [47:0]        mx;
    logic signed [MOP_W-1:0]   mb;

    always_comb begin
        pair = cmd.cnt[3:1];
        coef = '0;
        mx   = '0;
        if (cmd.mul_pid) begin
            case (pair)
                3'd0: begin
                    coef = signed'({1'b0, gains_reg[15:0]});
                    mx   = 48'(e_reg);
                end
                3'd1: begin
                    coef = signed'({1'b0, gains_reg[31:16]});
                    mx   = integ_reg;
                end
                default: begin
                    coef = signed'({1'b0, gains_reg[47:32]});
                    mx   = 48'(diff_reg);
                end
            endcase
        end else begin
            case (pair)
                3'd0: begin
                    coef = COEF_W'(signed'(fnum_reg[15:0]));
                    mx   = 48'(raw0_reg);
                end
                3'd1: begin
                    coef = COEF_W'(signed'(fnum_reg[31:16]));
                    mx   = 48'(reh0_reg);
                end
                3'd2: begin
                    coef = COEF_W'(signed'(fnum_reg[47:32]));
                    mx   = 48'(reh1_reg);
                end
                3'd3: begin
                    coef = -COEF_W'(signed'(fden_reg[15:0]));
                    mx   = 48'(feh0_reg);
                end
                default: begin
                    coef = -COEF_W'(signed'(fden_reg[31:16]));
                    mx   = 48'(feh1_reg);
                end
            endcase
        end
        if (cmd.cnt[0]) begin
            mb = MOP_W'(signed'(mx[47:24]));
        end else begin
            mb = signed'({1'b0, mx[23:0]});
        end
    end

    // filter result and integrator
    logic signed [POS_W-1:0]   e_new;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [ACC_W-1:0]   prod_ext;

    always_comb begin
        e_new     = sat40(acc_reg >>> 14);
        integ_new = sat48(ACC_W'(integ_reg) + ACC_W'(e_new));
        prod_ext  = ACC_W'(prod_reg);
        if (pend_hi_reg) begin
            prod_ext = prod_ext <<< 24;
        end
    end

    // effort, clamp, peak budget
    logic signed [63:0]      s64;
    logic signed [64:0]      s_adj;
    logic signed [47:0]      u;
    logic [47:0]             mag;
    logic [EFF_W-1:0]        lim, mag_c;
    logic                    use_peak, positive;
    logic [20:0]             thresh;
    logic signed [16:0]      pc_sum;
    logic signed [PC_W-1:0]  pc_new;
    logic signed [DRIVE_W-1:0] drive;
    logic [POS_W-1:0]        e_abs;

    always_comb begin
        s64   = sat64(acc_reg);
        s_adj = 65'(s64);
        if (s64 < 0) begin
            s_adj = s_adj + 65'sd65535;
        end
        u = en_reg ? s_adj[63:16] : '0;
        mag = u[47] ? 48'(-u) : 48'(u);
        thresh = 21'(GAIN13_NUM) * 21'(eff_lim_reg);
        pc_sum = 17'(pc_reg) + signed'({2'b00, peak_step_reg});
        use_peak = !({mag, 8'h00} < 56'(thresh))
                 && (pc_sum <= signed'({2'b00, peak_budget_reg}));
        if (use_peak) begin
            lim    = peak_lim_reg;
            pc_new = pc_sum[PC_W-1:0];
        end else begin
            lim    = eff_lim_reg;
            pc_new = (pc_reg != signed'({1'b1, {(PC_W-1){1'b0}}})) ? pc_reg - 1'b1 : pc_reg;
        end
        mag_c    = (mag > 48'(lim)) ? lim : mag[EFF_W-1:0];
        positive = !u[47] && (mag_c != '0);
        if (positive) begin
            drive = -signed'({2'b00, y_reg}) - signed'({2'b00, phase_adv_reg});
        end else begin
            drive = -signed'({2'b00, y_reg}) + signed'({2'b00, phase_adv_reg});
        end
        e_abs = e_reg[POS_W-1] ? POS_W'(-e_reg) : POS_W'(e_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_angle_reg <= '0;
            turn_reg       <= '0;
            held_reg       <= '0;
            reh0_reg       <= '0;
            reh1_reg       <= '0;
            feh0_reg       <= '0;
            feh1_reg       <= '0;
            integ_reg      <= '0;
            pc_reg         <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_reg <= cmd.mul_issue;
            if (cmd.accept) begin
                if (in_load) begin
                    held_reg <= in_target;
                end
            end
            if (cmd.unwrap) begin
                turn_reg <= turn_new;
                pos_reg  <= pos_sum[POS_W-1:0];
            end
            if (cmd.error) begin
                if (en_reg) begin
                    raw0_reg <= sat40(ACC_W'(held_reg) - ACC_W'(pos_reg));
                end else begin
                    raw0_reg  <= reh0_reg;
                    e_reg     <= feh0_reg;
                    integ_reg <= '0;
                    held_reg  <= pos_reg;
                end
            end
            if (cmd.filt_done) begin
                e_reg     <= e_new;
                integ_reg <= integ_new;
                diff_reg  <= (POS_W+1)'(e_new) - (POS_W+1)'(feh0_reg);
            end
            if (cmd.finish) begin
                last_angle_reg <= y_reg;
                reh1_reg       <= reh0_reg;
                reh0_reg       <= raw0_reg;
                feh1_reg       <= feh0_reg;
                feh0_reg       <= e_reg;
                pc_reg         <= pc_new;
                out_valid_reg  <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            y_reg     <= in_angle;
            en_reg    <= in_enable;
        end
        if (cmd.mul_issue) begin
            prod_reg    <= coef * mb;
            pend_hi_reg <= cmd.cnt[0];
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (pend_reg) begin
            acc_reg <= acc_reg + prod_ext;
        end
        if (cmd.finish) begin
            out_drive_reg  <= drive;
            out_effort_reg <= mag_c;
            out_at_reg     <= (e_abs < AT_THRESH);
            out_pos_reg    <= pos_reg;
        end
    end

    assign status.en       = en_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_drive       = out_drive_reg;
    assign out_effort      = out_effort_reg;
    assign out_at_target   = out_at_reg;
    assign out_position    = out_pos_reg;

endmodule

// ===== sv/servo_position_loop_step_unit.sv =====
// Top level of the servo position loop step unit: stream ports, controller and datapath.
//
//  channel   | dir | payload
//  s_axis    | in  | tdata: shaft_angle, target_value; tuser: enable, load_target
//  m_axis    | out | tdata: drive_angle, drive_effort, position; tuser: at_target
//  cfg       | in  | register index, write data
//
// An enabled tick passes 10 filter and 6 PID partial products one at a time through
// the shared 17x25 multiplier before it loads the result register.
// A disabled tick skips the multiplier and goes on to load the result register.
// Reset is synchronous, active low; sets config defaults, clears part of loop state.
// A result held by a stalled m_tready blocks only the final step of the next tick.
module servo_position_loop_step_unit
    import splstep_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // shaft_angle[16:0], target_value[56:17], zero pad
    input  logic [1:0]           s_tuser,   // enable[0], load_target[1]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // drive_angle[18:0], drive_effort[30:19],
                                            // position[70:31], zero pad
    output logic                 m_tuser,   // at_target
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    splstep_cmd_t              ctrl_cmd;
    splstep_status_t           dp_status;
    logic signed [DRIVE_W-1:0] drive;
    logic [EFF_W-1:0]          effort;
    logic signed [POS_W-1:0]   position;

    splstep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    splstep_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_angle      (s_tdata[16:0]),
        .in_enable     (s_tuser[0]),
        .in_load       (s_tuser[1]),
        .in_target     (signed'(s_tdata[56:17])),
        .cmd           (ctrl_cmd),
        .status        (dp_status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_drive     (drive),
        .out_effort    (effort),
        .out_at_target (m_tuser),
        .out_position  (position)
    );

    assign m_tdata = {1'b0, position, effort, drive};

`ifndef SYNTHESIS
    a_accept_drops_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after transaction");

    a_finish_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.finish |=> m_tvalid)
        else $error("result not presented after finish");

    a_output_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctrl_cmd.finish))
        else $error("result presented without finish");
`endif

endmodule
